// ===== rtl/core/cubic_bezier_flattener_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the curve flattener
// Shared forms for the concurrent checks at the end of the core modules.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_FLATTENER_ASSERT_SVH
`define CUBIC_BEZIER_FLATTENER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be true.
`define CBF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Curve flattener package
// Shared widths, codes, item types and the coordinate clamp.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Field widths.
  localparam int COORD_W  = 32;
  localparam int SEG_W    = 7;
  localparam int T_W      = 17;
  localparam int W_W      = 31;
  localparam int SAT_IN_W = 34;

  // One in Q1.16.
  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  // Reset value of the segment count register.
  localparam logic [SEG_W-1:0] SEG_RESET = 7'd16;

  // Opcodes.
  localparam logic OP_LINE_TO   = 1'b0;
  localparam logic OP_BEZIER_TO = 1'b1;

  // Register index as decoded from the word address.
  localparam logic REG_SEGMENT_COUNT = 1'b0;

  // Back end pipeline and queues.
  localparam int PIPE_STAGES = 6;
  localparam int OQ_DEPTH    = 16;
  localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);
  localparam int IQ_DEPTH    = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][COORD_W-1:0] point_t;

  // One classified item: point count, step of t as quotient and remainder,
  // and the four curve points (0 is the start point, 3 is the end point).
  typedef struct packed {
    logic [SEG_W-1:0]   n;
    logic [T_W-1:0]     q0;
    logic [SEG_W-1:0]   r0;
    point_t [3:0]       p;
  } item_t;

  typedef struct packed {
    point_t pt;
    logic   last;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

  // Clamp a value to the signed range of sat_w bits.
  function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v,
                                       input int unsigned sat_w);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = (SAT_IN_W'(1) << (sat_w - 1)) - SAT_IN_W'(1);
    lo = ~hi;
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/cbf_fifo.sv =====
// ----------------------------------------------------------------------------
// Curve flattener queue
// Register-based first-in first-out queue with a fill count; DEPTH >= 2.
// ----------------------------------------------------------------------------
module cbf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 wdata,
  output logic                             full,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 rdata,
  output logic                             empty,
  output logic [$clog2(DEPTH + 1)-1:0]     count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tracks the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/cbf_front.sv =====
// ----------------------------------------------------------------------------
// Curve flattener front end
// Accepts items, tracks the current point and works out the step of t.
// ----------------------------------------------------------------------------
`include "cubic_bezier_flattener_assert.svh"

module cbf_front import cbf_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int SAT_WIDTH    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             opcode,
  input  point_t           end_pt,
  input  point_t           ctrl1_pt,
  input  point_t           ctrl2_pt,
  input  logic [SEG_W-1:0] segment_count,
  output logic             q_push,
  output item_t            q_item,
  input  logic             q_full
);

  localparam int N_MAX = (MAX_SEGMENTS < 127) ? MAX_SEGMENTS : 127;
  localparam logic [SEG_W-1:0] N_MAX_V = SEG_W'(N_MAX);
  localparam logic [4:0] DIV_LAST = 5'(T_W - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;

  logic [1:0]       state;
  item_t            hold;
  point_t           cur;
  point_t           cur_next;
  logic             cache_ok;
  logic [SEG_W-1:0] cache_n;
  logic [T_W-1:0]   cache_q0;
  logic [SEG_W-1:0] cache_r0;
  logic [SEG_W-1:0] div_rem;
  logic [T_W-1:0]   div_dvd;
  logic [4:0]       div_cnt;
  logic [SEG_W:0]   div_sh;
  logic             div_ge;
  logic [SEG_W-1:0] div_rem_next;
  logic [T_W-1:0]   div_dvd_next;
  logic             can_take;
  logic             accept;
  logic             is_line;
  logic [SEG_W-1:0] n_eff;
  logic             cache_hit;

  // Handshake: a new item enters when idle or while the held one leaves.
  assign can_take = (state == ST_IDLE) || ((state == ST_ISSUE) && !q_full);
  assign full     = !can_take;
  assign accept   = push && can_take;
  assign q_push   = (state == ST_ISSUE) && !q_full;
  assign q_item   = hold;
  assign is_line  = (opcode == OP_LINE_TO);

  // Point count: zero counts as one, large values clamp to the maximum.
  always_comb begin
    if (segment_count == '0) begin
      n_eff = SEG_W'(1);
    end else if (segment_count > N_MAX_V) begin
      n_eff = N_MAX_V;
    end else begin
      n_eff = segment_count;
    end
  end

  assign cache_hit = cache_ok && (cache_n == n_eff);

  // Every item leaves the clamped end point as the new current point.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cur_next[j] = sat_coord(SAT_IN_W'($signed(end_pt[j])), SAT_WIDTH);
    end
  end

  // Restoring divider for one over n, one quotient bit per cycle.
  assign div_sh       = {div_rem, div_dvd[T_W-1]};
  assign div_ge       = (div_sh >= {1'b0, hold.n});
  assign div_rem_next = div_ge ? SEG_W'(div_sh - {1'b0, hold.n}) : div_sh[SEG_W-1:0];
  assign div_dvd_next = {div_dvd[T_W-2:0], div_ge};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= '0;
      cache_ok <= 1'b0;
      div_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE, ST_ISSUE: begin
          if (accept) begin
            cur     <= cur_next;
            div_cnt <= '0;
            state   <= (!is_line && !cache_hit) ? ST_DIV : ST_ISSUE;
          end else if ((state == ST_ISSUE) && !q_full) begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            cache_ok <= 1'b1;
            state    <= ST_ISSUE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Held item, divider data and the cached step.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold.p  <= {end_pt, ctrl2_pt, ctrl1_pt, cur};
      hold.n  <= is_line ? SEG_W'(1) : n_eff;
      hold.q0 <= is_line ? ONE_Q16 : cache_q0;
      hold.r0 <= is_line ? '0 : cache_r0;
      div_rem <= '0;
      div_dvd <= ONE_Q16;
    end else if (state == ST_DIV) begin
      div_rem <= div_rem_next;
      div_dvd <= div_dvd_next;
      if (div_cnt == DIV_LAST) begin
        hold.q0  <= div_dvd_next;
        hold.r0  <= div_rem_next;
        cache_n  <= hold.n;
        cache_q0 <= div_dvd_next;
        cache_r0 <= div_rem_next;
      end
    end
  end

  // The step handed on must split one exactly into n parts.
  `CBF_ASSERT_IMP(a_step_exact, state == ST_ISSUE,
    (32'(hold.q0) * 32'(hold.n) + 32'(hold.r0) == 32'(ONE_Q16)) && (hold.r0 < hold.n),
    "front: step of t does not divide one by n")
  `CBF_ASSERT_NXT(a_div_exit, state == ST_DIV,
    state == ST_DIV || state == ST_ISSUE, "front: divider left to a wrong state")
  `CBF_ASSERT_NXT(a_accept_busy, accept, state != ST_IDLE,
    "front: accepted item was dropped")

endmodule

// ===== rtl/core/cbf_back.sv =====
// ----------------------------------------------------------------------------
// Curve flattener back end
// Steps t over each item and evaluates one curve point per cycle while the output credit allows.
// ----------------------------------------------------------------------------
`include "cubic_bezier_flattener_assert.svh"

module cbf_back import cbf_pkg::*; #(
  parameter int SAT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  item_t               q_item,
  output logic                o_push,
  output result_t             o_data,
  input  logic [OQ_CNT_W-1:0] o_count
);

  localparam int OCC_W = $clog2(OQ_DEPTH + PIPE_STAGES + 1);
  localparam int RAW_W = 49;
  localparam logic [50:0] RND_Q30 = 51'h20000;
  localparam logic signed [63:0] RND_ACC = 64'sh20000000;

  // Stepper state.
  logic             active;
  item_t            item;
  logic [SEG_W-1:0] i;
  logic [T_W-1:0]   q;
  logic [SEG_W-1:0] r;
  logic [SEG_W:0]   sum_r;
  logic             carry;
  logic [SEG_W-1:0] r_step;
  logic [T_W-1:0]   t_step;
  logic [SEG_W-1:0] i_step;
  logic             step_last;
  logic             issue;
  logic             credit_ok;
  logic [OCC_W-1:0] occ;

  // Pipeline registers.
  logic                      a_v, b_v, c_v, d_v, e_v, f_v;
  logic                      a_last, b_last, c_last, d_last, e_last, f_last;
  point_t [3:0]              a_pts, b_pts, c_pts, d_pts;
  logic [T_W-1:0]            a_t, a_s, b_t, b_s;
  logic [32:0]               b_s2, b_t2;
  logic [3:0][RAW_W-1:0]     c_w;
  logic [3:0][W_W-1:0]       d_w;
  logic [3:0][2:0][63:0]     e_prod;
  logic [2:0][63:0]          f_lo, f_hi;

  // Combinational values between stages.
  logic [33:0]               ss_p, tt_p;
  logic [49:0]               c_p0, c_p1, c_p2, c_p3;
  logic [50:0]               d_r0, d_r1, d_r2, d_r3;
  logic [3:0][2:0][63:0]     e_next;
  logic signed [63:0]        acc [3];
  point_t                    fin;

  // Credit: results in flight plus results queued never exceed the queue.
  always_comb begin
    occ = OCC_W'(o_count) + OCC_W'($countones({a_v, b_v, c_v, d_v, e_v, f_v}));
  end
  assign credit_ok = (occ < OCC_W'(OQ_DEPTH));
  assign issue     = active && credit_ok;

  // Next t as quotient plus remainder of (i * one + n / 2) / n.
  assign sum_r     = {1'b0, r} + {1'b0, item.r0};
  assign carry     = (sum_r >= {1'b0, item.n});
  assign r_step    = carry ? SEG_W'(sum_r - {1'b0, item.n}) : sum_r[SEG_W-1:0];
  assign t_step    = q + item.q0 + T_W'(carry);
  assign i_step    = i + SEG_W'(1);
  assign step_last = (i_step == item.n);

  assign q_pop = !q_empty && (!active || (issue && step_last));

  // Stepper control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (issue && step_last) begin
      active <= 1'b0;
    end
  end

  // Stepper data.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
      q    <= '0;
      r    <= q_item.n >> 1;
      i    <= '0;
    end else if (issue) begin
      q <= t_step;
      r <= r_step;
      i <= i_step;
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
    end else begin
      a_v <= issue;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
    end
  end

  // Squares, cubes and rounded weights.
  assign ss_p = a_s * a_s;
  assign tt_p = a_t * a_t;
  assign c_p0 = b_s2 * b_s;
  assign c_p1 = b_s2 * b_t;
  assign c_p2 = b_t2 * b_s;
  assign c_p3 = b_t2 * b_t;
  assign d_r0 = 51'(c_w[0]) + RND_Q30;
  assign d_r1 = 51'(c_w[1]) + (51'(c_w[1]) << 1) + RND_Q30;
  assign d_r2 = 51'(c_w[2]) + (51'(c_w[2]) << 1) + RND_Q30;
  assign d_r3 = 51'(c_w[3]) + RND_Q30;

  // Weight times coordinate for each of the four points and three axes.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        e_next[k][j] = $signed({1'b0, d_w[k]}) * $signed(d_pts[k][j]);
      end
    end
  end

  // Final sum, rounding to Q16.16 and clamping.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = $signed(f_lo[j]) + $signed(f_hi[j]);
      fin[j] = sat_coord($signed(acc[j][63:30]), SAT_WIDTH);
    end
  end

  assign o_push      = f_v;
  assign o_data.pt   = fin;
  assign o_data.last = f_last;

  // Pipeline data.
  always_ff @(posedge clk) begin
    a_t    <= t_step;
    a_s    <= ONE_Q16 - t_step;
    a_last <= step_last;
    a_pts  <= item.p;

    b_s2   <= ss_p[32:0];
    b_t2   <= tt_p[32:0];
    b_s    <= a_s;
    b_t    <= a_t;
    b_last <= a_last;
    b_pts  <= a_pts;

    c_w[0] <= c_p0[RAW_W-1:0];
    c_w[1] <= c_p1[RAW_W-1:0];
    c_w[2] <= c_p2[RAW_W-1:0];
    c_w[3] <= c_p3[RAW_W-1:0];
    c_last <= b_last;
    c_pts  <= b_pts;

    d_w[0] <= d_r0[48:18];
    d_w[1] <= d_r1[48:18];
    d_w[2] <= d_r2[48:18];
    d_w[3] <= d_r3[48:18];
    d_last <= c_last;
    d_pts  <= c_pts;

    e_prod <= e_next;
    e_last <= d_last;

    for (int j = 0; j < 3; j++) begin
      f_lo[j] <= $signed(e_prod[0][j]) + $signed(e_prod[1][j]);
      f_hi[j] <= $signed(e_prod[2][j]) + $signed(e_prod[3][j]) + RND_ACC;
    end
    f_last <= e_last;
  end

  `CBF_ASSERT_NEVER(a_credit, occ > OCC_W'(OQ_DEPTH),
    "back: more results in flight than the output queue holds")
  `CBF_ASSERT_IMP(a_last_at_one, a_v && a_last, a_t == ONE_Q16,
    "back: last point of an item is not at t equal to one")
  `CBF_ASSERT_IMP(a_inner_below_one, a_v && !a_last, a_t < ONE_Q16,
    "back: inner point reached t equal to one")
  `CBF_ASSERT_NXT(a_item_done, issue && step_last && !q_pop, !active,
    "back: stepper kept running past the last point")

endmodule

// ===== rtl/core/cubic_bezier_flattener.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier flattener
// Builds a path of 3D Q16.16 points from line and cubic curve items. A line
// item gives one point, its clamped end point. A curve item runs from the
// current point through two control points to its end point and gives
// segment_count points (zero as one, capped at MAX_SEGMENTS and at 127) at
// t = i/n, one per cycle while the output queue credit allows, from a
// six-stage evaluation pipeline. When the point count differs from that of
// the previous curve, the front end first works out the step of t in its
// bit-serial divider; this overlaps with the points of earlier items still
// being emitted. An item passes from the front end's hold register through
// the item queue, the stepper and stages a to f into the output queue.
// Results wait in a 16-entry output queue, items in a two-entry queue between
// the front and the back end. The current point resets to the origin and
// segment_count to 16; write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "cubic_bezier_flattener_assert.svh"

module cubic_bezier_flattener import cbf_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Item side.
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] end_x,
  input  logic [31:0] end_y,
  input  logic [31:0] end_z,
  input  logic [31:0] ctrl1_x,
  input  logic [31:0] ctrl1_y,
  input  logic [31:0] ctrl1_z,
  input  logic [31:0] ctrl2_x,
  input  logic [31:0] ctrl2_y,
  input  logic [31:0] ctrl2_z,
  // Result side.
  input  logic        pop,
  output logic        empty,
  output logic [31:0] point_x,
  output logic [31:0] point_y,
  output logic [31:0] point_z,
  output logic        is_last,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SAT_WIDTH = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int IQ_CNT_W  = $clog2(IQ_DEPTH + 1);

  logic [SEG_W-1:0] segment_count;
  point_t           end_pt;
  point_t           ctrl1_pt;
  point_t           ctrl2_pt;
  logic             iq_push;
  item_t            iq_wdata;
  logic             iq_full;
  logic             iq_pop;
  item_t            iq_rdata;
  logic             iq_empty;
  logic [IQ_CNT_W-1:0] iq_count;
  logic             oq_push;
  result_t          oq_wdata;
  logic             oq_full;
  result_t          oq_rdata;
  logic [OQ_CNT_W-1:0] oq_count;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= SEG_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SEGMENT_COUNT)) begin
      segment_count <= pwdata[SEG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? 32'(segment_count) : '0;

  assign end_pt   = {end_z, end_y, end_x};
  assign ctrl1_pt = {ctrl1_z, ctrl1_y, ctrl1_x};
  assign ctrl2_pt = {ctrl2_z, ctrl2_y, ctrl2_x};

  // Front end: accepts and classifies items.
  cbf_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SAT_WIDTH    (SAT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .end_pt        (end_pt),
    .ctrl1_pt      (ctrl1_pt),
    .ctrl2_pt      (ctrl2_pt),
    .segment_count (segment_count),
    .q_push        (iq_push),
    .q_item        (iq_wdata),
    .q_full        (iq_full)
  );

  // Queue of classified items.
  cbf_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (IQ_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (iq_push),
    .wdata (iq_wdata),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty),
    .count (iq_count)
  );

  // Back end: steps t and evaluates the points.
  cbf_back #(
    .SAT_WIDTH (SAT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (iq_empty),
    .q_pop   (iq_pop),
    .q_item  (iq_rdata),
    .o_push  (oq_push),
    .o_data  (oq_wdata),
    .o_count (oq_count)
  );

  // Output queue of result items.
  cbf_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty),
    .count (oq_count)
  );

  assign point_x = oq_rdata.pt[0];
  assign point_y = oq_rdata.pt[1];
  assign point_z = oq_rdata.pt[2];
  assign is_last = oq_rdata.last;

  // The credit scheme in the back end keeps results from being written into a full output queue.
  `CBF_ASSERT_NEVER(a_oq_overrun, oq_push && oq_full,
    "top: result written into a full output queue")
  // The front end only hands on an item when the item queue has room.
  `CBF_ASSERT_NEVER(a_iq_overrun, iq_push && iq_full,
    "top: item written into a full item queue")
  `CBF_ASSERT_NEVER(a_iq_count, iq_count > IQ_CNT_W'(IQ_DEPTH),
    "top: item queue holds more than its depth")

endmodule
